[sv/velocity_form_pid_controller_defines.svh]
// Assertion macros for the incremental PID controller.
// Included by the top-level RTL file, which checks its own control logic.
`ifndef VELOCITY_FORM_PID_CONTROLLER_DEFINES_SVH
`define VELOCITY_FORM_PID_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define VFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VFPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VFPC_ASSERT(lbl, prop, msg)
`define VFPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/vfpc_pkg.sv]
// Shared types and widths of the incremental PID controller.
// No dependencies.
`default_nettype none
package vfpc_pkg;

  localparam int MULT_W     = 16;
  localparam int MULT_CNT_W = 4;
  localparam int MCAND_W    = 34;
  localparam int PROD_W     = MCAND_W + MULT_W;
  localparam int DIV_W      = PROD_W;
  localparam int DIV_CNT_W  = 6;
  localparam int DVSR_W     = 16;
  localparam int COEF_W     = 35;
  localparam int ACC_W      = 52;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 16;
  localparam int DRV_W      = 32;
  localparam logic [1:0] LAST_TERM = 2'd2;

  typedef enum logic [1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_PER
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_KD,
    ST_DIV_C1,
    ST_MUL_KI,
    ST_DIV_C3,
    ST_COEF,
    ST_MUL_T,
    ST_DIV_T,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

[sv/vfpc_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on vfpc_pkg.
`default_nettype none
module vfpc_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [vfpc_pkg::MCAND_W-1:0] mcand,
  input  wire logic [vfpc_pkg::MULT_W-1:0]  mplier,
  output vfpc_pkg::unit_stat_t              stat,
  output logic      [vfpc_pkg::PROD_W-1:0]  prod
);
  import vfpc_pkg::*;

  logic [MCAND_W-1:0]    a_r;
  logic [MCAND_W:0]      hi_r;
  logic [MULT_W-1:0]     lo_r;
  logic [MULT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [MCAND_W:0]      sum;

  always_comb begin
    sum = hi_r + (lo_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MULT_CNT_W'(MULT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= mcand;
      hi_r <= '0;
      lo_r <= mplier;
    end else if (busy_r) begin
      hi_r <= {1'b0, sum[MCAND_W:1]};
      lo_r <= {sum[0], lo_r[MULT_W-1:1]};
    end
  end

  assign prod      = {hi_r[MCAND_W-1:0], lo_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

[sv/vfpc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on vfpc_pkg.
`default_nettype none
module vfpc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [vfpc_pkg::DIV_W-1:0]  dividend,
  input  wire logic [vfpc_pkg::DVSR_W-1:0] divisor,
  output vfpc_pkg::unit_stat_t             stat,
  output logic      [vfpc_pkg::DIV_W-1:0]  quo,
  output logic      [vfpc_pkg::DVSR_W-1:0] rem
);
  import vfpc_pkg::*;

  logic [DIV_W-1:0]     quo_r;
  logic [DVSR_W-1:0]    rem_r;
  logic [DVSR_W-1:0]    dvsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DVSR_W:0]      trial;
  logic [DVSR_W:0]      diff;
  logic                 fits;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dvsr_r};
    fits  = trial >= {1'b0, dvsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign quo       = quo_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

[sv/velocity_form_pid_controller.sv]
// Top level of the incremental PID controller: sequencer, registers, APB port.
// Depends on vfpc_pkg, vfpc_mul, vfpc_div and the assertion macro header.
//
// One error sample in, one saturated drive value out per request; the result is
// loaded once the output is free. All arithmetic runs through one bit-serial
// multiplier and one bit-serial divider: two multiply/divide passes form the
// coefficients from the gain and period registers, then three more form the
// terms q*e/SCALE, which are summed with the previous output and clamped to 32
// bits. A new sample is taken when the sequencer is idle, even while the last
// result still waits on the output. A sample_period of zero counts as one.
`default_nettype none
`include "velocity_form_pid_controller_defines.svh"
module velocity_form_pid_controller #(
  parameter int SCALE = 1000
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_error_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_drive_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import vfpc_pkg::*;

  state_t state_r, state_nxt;
  logic   go_r;

  logic [GAIN_W-1:0] kp_r, ki_r, kd_r, per_r;
  logic [GAIN_W-1:0] per_eff;
  reg_idx_t          reg_idx;

  logic [ERR_W-1:0]        e_r [3];
  logic [DRV_W-1:0]        drive_prev_r;
  logic [30:0]             c1_r;
  logic [31:0]             c2_r;
  logic [31:0]             c3_r;
  logic signed [COEF_W-1:0] q_r [3];
  logic [1:0]              term_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    out_valid_r;
  logic [DRV_W-1:0]        out_drive_r;

  logic               mul_start, div_start;
  logic [MCAND_W-1:0] mul_a;
  logic [MULT_W-1:0]  mul_b;
  logic [DIV_W-1:0]   div_dvd;
  logic [DVSR_W-1:0]  div_dvsr;
  unit_stat_t         mul_stat, div_stat;
  logic [PROD_W-1:0]  mul_prod;
  logic [DIV_W-1:0]   div_quo;
  logic [DVSR_W-1:0]  div_rem;

  logic signed [COEF_W-1:0] q_sel;
  logic [ERR_W-1:0]         e_sel;
  logic [MCAND_W-1:0]       q_mag;
  logic [MULT_W-1:0]        e_mag;
  logic                     term_neg;
  logic [ACC_W-1:0]         term_val;
  logic                     sat_hi, sat_lo;
  logic [DRV_W-1:0]         sat_val;
  logic                     out_free;
  logic [DVSR_W:0]         rem2;

  assign per_eff  = (per_r == '0) ? GAIN_W'(1) : per_r;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign pready   = 1'b1;
  assign out_free = !out_valid_r || out_ready;

  vfpc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .stat   (mul_stat),
    .prod   (mul_prod)
  );

  vfpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvsr),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= GAIN_W'(1000);
      ki_r  <= '0;
      kd_r  <= '0;
      per_r <= GAIN_W'(1000);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_KP:  kp_r  <= pwdata[GAIN_W-1:0];
        REG_KI:  ki_r  <= pwdata[GAIN_W-1:0];
        REG_KD:  kd_r  <= pwdata[GAIN_W-1:0];
        REG_PER: per_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KP:  prdata = 32'(kp_r);
      REG_KI:  prdata = 32'(ki_r);
      REG_KD:  prdata = 32'(kd_r);
      REG_PER: prdata = 32'(per_r);
      default: prdata = '0;
    endcase
  end

  // current term operands
  always_comb begin
    q_sel    = q_r[term_r];
    e_sel    = e_r[term_r];
    q_mag    = q_sel[COEF_W-1] ? MCAND_W'(-q_sel) : MCAND_W'(q_sel);
    e_mag    = e_sel[ERR_W-1] ? MULT_W'(-e_sel) : MULT_W'(e_sel);
    term_neg = q_sel[COEF_W-1] ^ e_sel[ERR_W-1];
    term_val = ACC_W'(div_quo);
    rem2     = {div_rem, 1'b0};
  end

  always_comb begin
    sat_hi = acc_r > $signed({{(ACC_W-DRV_W){1'b0}}, 32'h7FFF_FFFF});
    sat_lo = acc_r < $signed({{(ACC_W-DRV_W){1'b1}}, 32'h8000_0000});
    if (sat_hi) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (sat_lo) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = acc_r[DRV_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_KD;
      ST_MUL_KD: if (mul_stat.done) state_nxt = ST_DIV_C1;
      ST_DIV_C1: if (div_stat.done) state_nxt = ST_MUL_KI;
      ST_MUL_KI: if (mul_stat.done) state_nxt = ST_DIV_C3;
      ST_DIV_C3: if (div_stat.done) state_nxt = ST_COEF;
      ST_COEF:   state_nxt = ST_MUL_T;
      ST_MUL_T:  if (mul_stat.done) state_nxt = ST_DIV_T;
      ST_DIV_T: begin
        if (div_stat.done) begin
          state_nxt = (term_r == LAST_TERM) ? ST_OUT : ST_MUL_T;
        end
      end
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = q_mag;
    mul_b     = e_mag;
    div_dvd   = mul_prod;
    div_dvsr  = DVSR_W'(SCALE);
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL_KD: begin
        mul_start = go_r;
        mul_a     = MCAND_W'(SCALE);
        mul_b     = kd_r;
      end
      ST_DIV_C1: begin
        div_start = go_r;
        div_dvsr  = per_eff;
      end
      ST_MUL_KI: begin
        mul_start = go_r;
        mul_a     = MCAND_W'(ki_r);
        mul_b     = per_eff;
      end
      ST_DIV_C3: div_start = go_r;
      ST_MUL_T:  mul_start = go_r;
      ST_DIV_T:  div_start = go_r;
      ST_COEF, ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      go_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      e_r[0]       <= '0;
      e_r[1]       <= '0;
      e_r[2]       <= '0;
      drive_prev_r <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= state_nxt != state_r;
      if (in_valid && in_ready) begin
        e_r[0] <= in_error_sample;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r  <= 1'b1;
        e_r[2]       <= e_r[1];
        e_r[1]       <= e_r[0];
        drive_prev_r <= sat_val;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_C1 && div_stat.done) begin
      c1_r <= div_quo[30:0];
      c2_r <= {div_quo[30:0], 1'b0} + 32'(rem2 >= {1'b0, per_eff});
    end
    if (state_r == ST_DIV_C3 && div_stat.done) begin
      c3_r <= div_quo[32:1];
    end
    if (state_r == ST_COEF) begin
      q_r[0] <= COEF_W'(kp_r) + COEF_W'(c1_r) + COEF_W'(c3_r);
      q_r[1] <= COEF_W'(c3_r) - COEF_W'(kp_r) - COEF_W'(c2_r);
      q_r[2] <= COEF_W'(c1_r);
      acc_r  <= ACC_W'($signed(drive_prev_r));
      term_r <= '0;
    end
    if (state_r == ST_DIV_T && div_stat.done) begin
      acc_r  <= term_neg ? acc_r - $signed(term_val) : acc_r + $signed(term_val);
      term_r <= term_r + 1'b1;
    end
    if (state_r == ST_OUT && out_free) begin
      out_drive_r <= sat_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;

  `VFPC_ASSERT(a_accept_busy, (in_valid && in_ready) |=> !in_ready, "sample taken while busy")
  `VFPC_ASSERT(a_idle_units, (state_r == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy), "unit busy in idle")
  `VFPC_ASSERT(a_load_out, $rose(out_valid) |-> $past(state_r == ST_OUT), "result loaded outside output state")

endmodule
`default_nettype wire
